// File: src/lif_pkg.sv
// ----------------------------------------------------------------------------
// lif_pkg
// Shared widths, codes, control structs and helpers for the LIF neuron update.
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int NEURON_COUNT = 1024;
  localparam int ADDR_W       = $clog2(NEURON_COUNT);

  localparam int ID_W       = 10;
  localparam int V_W        = 32;
  localparam int CNT_W      = 16;
  localparam int NOISE_W    = 16;
  localparam int DECAY_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MEM_W  = CNT_W + V_W;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // round half up terms for the two rescaling shifts
  localparam int NOISE_SHIFT = 12;
  localparam int SUM_SHIFT   = 24;
  localparam logic signed [PROD_W-1:0] NOISE_HALF = PROD_W'(1) << (NOISE_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SUM_HALF   = PROD_W'(1) << (SUM_SHIFT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_COEFF      = 3'd0,
    REG_INPUT_GAIN       = 3'd1,
    REG_BIAS_CURRENT     = 3'd2,
    REG_NOISE_GAIN       = 3'd3,
    REG_V_THRESHOLD      = 3'd4,
    REG_V_RESET          = 3'd5,
    REG_REFRACTORY_STEPS = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_NOISE,
    MUL_DECAY,
    MUL_GAIN
  } mul_sel_t;

  typedef enum logic [1:0] {
    KIND_OOR,
    KIND_HOLD,
    KIND_FIRE,
    KIND_INT
  } kind_t;

  typedef struct packed {
    logic [DECAY_W-1:0]    decay_coeff;
    logic [V_W-1:0]        input_gain;
    logic signed [V_W-1:0] bias_current;
    logic signed [V_W-1:0] noise_gain;
    logic signed [V_W-1:0] v_threshold;
    logic signed [V_W-1:0] v_reset;
    logic [CNT_W-1:0]      refractory_steps;
  } cfg_t;

  typedef struct packed {
    logic              ld_in;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              ld_drive;
    logic              ld_acc;
    logic              ld_sum;
    logic              ld_out;
    logic              wr_en;
    logic              clr;
    logic [ADDR_W-1:0] clr_addr;
    kind_t             kind;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic refr_busy;
    logic at_thr;
  } dp_status_t;

  function automatic logic signed [V_W-1:0] sat_v(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-V_W:0] top;
    top = x[PROD_W-1:V_W-1];
    if (top == '0 || top == '1) begin
      return x[V_W-1:0];
    end
    return x[PROD_W-1] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
  endfunction

endpackage

// File: src/lif_if.sv
// ----------------------------------------------------------------------------
// lif_if
// Valid/ready channel interfaces for neuron items, results and register writes.
// ----------------------------------------------------------------------------
interface lif_in_if;
  logic                              valid;
  logic                              ready;
  logic [lif_pkg::ID_W-1:0]          neuron_id;
  logic signed [lif_pkg::V_W-1:0]    synaptic_sum;
  logic signed [lif_pkg::NOISE_W-1:0] noise_sample;

  modport source (output valid, neuron_id, synaptic_sum, noise_sample, input ready);
  modport sink   (input valid, neuron_id, synaptic_sum, noise_sample, output ready);
endinterface

interface lif_out_if;
  logic                           valid;
  logic                           ready;
  logic [lif_pkg::ID_W-1:0]       out_neuron_id;
  logic                           fired;
  logic signed [lif_pkg::V_W-1:0] membrane_voltage;

  modport source (output valid, out_neuron_id, fired, membrane_voltage, input ready);
  modport sink   (input valid, out_neuron_id, fired, membrane_voltage, output ready);
endinterface

interface lif_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lif_pkg::CFG_IDX_W-1:0]   index;
  logic [lif_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/lif_cfg_regs.sv
// ----------------------------------------------------------------------------
// lif_cfg_regs
// Shared parameter set of the neuron population, written over the cfg channel.
// ----------------------------------------------------------------------------
module lif_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  lif_cfg_if.sink        cfg,
  output lif_pkg::cfg_t  regs
);
  import lif_pkg::*;

  cfg_t regs_r;
  cfg_t regs_nxt;

  assign cfg.ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_DECAY_COEFF:      regs_nxt.decay_coeff      = cfg.data[DECAY_W-1:0];
        REG_INPUT_GAIN:       regs_nxt.input_gain       = cfg.data[V_W-1:0];
        REG_BIAS_CURRENT:     regs_nxt.bias_current     = cfg.data[V_W-1:0];
        REG_NOISE_GAIN:       regs_nxt.noise_gain       = cfg.data[V_W-1:0];
        REG_V_THRESHOLD:      regs_nxt.v_threshold      = cfg.data[V_W-1:0];
        REG_V_RESET:          regs_nxt.v_reset          = cfg.data[V_W-1:0];
        REG_REFRACTORY_STEPS: regs_nxt.refractory_steps = cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// File: src/lif_ctrl.sv
// ----------------------------------------------------------------------------
// lif_ctrl
// Sequencer: state clearing sweep, per-item step through the shared multiplier,
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module lif_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lif_pkg::dp_status_t status,
  output lif_pkg::dp_cmd_t    cmd
);
  import lif_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MUL_D,
    S_MUL_G,
    S_SUM,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  kind_t             kind_r, kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign go        = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ready;

    cmd          = '0;
    cmd.mul_sel  = MUL_NOISE;
    cmd.clr_addr = clr_addr_r;
    cmd.kind     = kind_r;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr      = 1'b1;
        cmd.wr_en    = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(NEURON_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NOISE;
        if (!status.in_range) begin
          kind_nxt  = KIND_OOR;
          state_nxt = S_DONE;
        end else if (status.refr_busy) begin
          kind_nxt  = KIND_HOLD;
          state_nxt = S_DONE;
        end else if (status.at_thr) begin
          kind_nxt  = KIND_FIRE;
          state_nxt = S_DONE;
        end else begin
          kind_nxt  = KIND_INT;
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.ld_drive = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_DECAY;
        state_nxt    = S_MUL_G;
      end
      S_MUL_G: begin
        cmd.ld_acc  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (go) begin
          cmd.ld_out    = 1'b1;
          cmd.wr_en     = (kind_r != KIND_OOR);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      kind_r      <= KIND_OOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/lif_datapath.sv
// ----------------------------------------------------------------------------
// lif_datapath
// Neuron state memory, shared 33x33 multiplier, drive and voltage rounding,
// saturation and the result register.
// ----------------------------------------------------------------------------
module lif_datapath (
  input  logic                              clk,
  input  lif_pkg::cfg_t                     regs,
  input  lif_pkg::dp_cmd_t                  cmd,
  output lif_pkg::dp_status_t               status,
  input  logic [lif_pkg::ID_W-1:0]          in_neuron_id,
  input  logic signed [lif_pkg::V_W-1:0]    in_synaptic_sum,
  input  logic signed [lif_pkg::NOISE_W-1:0] in_noise_sample,
  output logic [lif_pkg::ID_W-1:0]          out_neuron_id,
  output logic                              out_fired,
  output logic signed [lif_pkg::V_W-1:0]    out_voltage
);
  import lif_pkg::*;

  logic [MEM_W-1:0] mem [NEURON_COUNT];

  logic [ID_W-1:0]          id_r;
  logic signed [V_W-1:0]    syn_r;
  logic signed [NOISE_W-1:0] noise_r;
  logic [MEM_W-1:0]         rd_data_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [V_W-1:0]    drive_r;
  logic signed [V_W-1:0]    int_v_r;
  logic [ID_W-1:0]          out_id_r;
  logic                     out_fired_r;
  logic signed [V_W-1:0]    out_v_r;

  logic signed [V_W-1:0]    rd_v;
  logic [CNT_W-1:0]         rd_cnt;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] nterm;
  logic signed [PROD_W-1:0] drive_sum;
  logic signed [PROD_W-1:0] total;
  logic signed [V_W-1:0]    res_v;
  logic [CNT_W-1:0]         res_cnt;
  logic                     res_fired;
  logic [ADDR_W-1:0]        wr_addr;
  logic [MEM_W-1:0]         wr_data;

  assign rd_v   = rd_data_r[V_W-1:0];
  assign rd_cnt = rd_data_r[MEM_W-1:V_W];

  assign status.in_range  = 32'(id_r) < 32'(NEURON_COUNT);
  assign status.refr_busy = (rd_cnt != '0);
  assign status.at_thr    = (rd_v >= regs.v_threshold);

  always_comb begin
    case (cmd.mul_sel)
      MUL_NOISE: begin
        mul_a = {{(MUL_W-NOISE_W){noise_r[NOISE_W-1]}}, noise_r};
        mul_b = {{(MUL_W-V_W){regs.noise_gain[V_W-1]}}, regs.noise_gain};
      end
      MUL_DECAY: begin
        mul_a = {{(MUL_W-DECAY_W){1'b0}}, regs.decay_coeff};
        mul_b = {{(MUL_W-V_W){rd_v[V_W-1]}}, rd_v};
      end
      MUL_GAIN: begin
        mul_a = {{(MUL_W-V_W){1'b0}}, regs.input_gain};
        mul_b = {{(MUL_W-V_W){drive_r[V_W-1]}}, drive_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // noise term rounds half up at 2^-12, total rounds half up at 2^-24
  assign nterm     = (prod_r + NOISE_HALF) >>> NOISE_SHIFT;
  assign drive_sum = {{(PROD_W-V_W){syn_r[V_W-1]}}, syn_r}
                   + {{(PROD_W-V_W){regs.bias_current[V_W-1]}}, regs.bias_current}
                   + nterm;
  assign total     = (acc_r + prod_r + SUM_HALF) >>> SUM_SHIFT;

  always_comb begin
    case (cmd.kind)
      KIND_HOLD: begin
        res_v     = rd_v;
        res_cnt   = rd_cnt - 1'b1;
        res_fired = 1'b0;
      end
      KIND_FIRE: begin
        res_v     = regs.v_reset;
        res_cnt   = regs.refractory_steps;
        res_fired = 1'b1;
      end
      KIND_INT: begin
        res_v     = int_v_r;
        res_cnt   = rd_cnt;
        res_fired = 1'b0;
      end
      default: begin
        res_v     = '0;
        res_cnt   = rd_cnt;
        res_fired = 1'b0;
      end
    endcase
  end

  assign wr_addr = cmd.clr ? cmd.clr_addr : ADDR_W'(id_r);
  assign wr_data = cmd.clr ? '0 : {res_cnt, res_v};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.ld_in) begin
      rd_data_r <= mem[ADDR_W'(in_neuron_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      id_r    <= in_neuron_id;
      syn_r   <= in_synaptic_sum;
      noise_r <= in_noise_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.ld_drive) begin
      drive_r <= sat_v(drive_sum);
    end
    if (cmd.ld_acc) begin
      acc_r <= prod_r;
    end
    if (cmd.ld_sum) begin
      int_v_r <= sat_v(total);
    end
    if (cmd.ld_out) begin
      out_id_r    <= id_r;
      out_fired_r <= res_fired;
      out_v_r     <= res_v;
    end
  end

  assign out_neuron_id = out_id_r;
  assign out_fired     = out_fired_r;
  assign out_voltage   = out_v_r;

endmodule

// File: src/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// lif_neuron_update
// Leaky integrate-and-fire population: one neuron advanced per input beat.
//
//   channel  dir  beat contents
//   in_ch    in   neuron_id, synaptic_sum, noise_sample
//   out_ch   out  out_neuron_id, fired, membrane_voltage
//   cfg_ch   in   index, data (register write, always ready)
//
// integrating step: S_READ, S_MUL_D, S_MUL_G, S_SUM, then S_DONE, with three passes
//   through the one shared multiplier; no new beat is taken until S_DONE
// refractory, firing or out of range step: S_READ, then S_DONE
// after reset a clearing sweep zeroes every word of the state memory,
//   with in_ready low; register writes are taken during it
// the next beat is accepted while a result still waits in the output register
// ----------------------------------------------------------------------------
module lif_neuron_update (
  input  logic    clk,
  input  logic    rst_n,
  lif_in_if.sink  in_ch,
  lif_out_if.source out_ch,
  lif_cfg_if.sink cfg_ch
);
  import lif_pkg::*;

  cfg_t       regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  lif_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (regs)
  );

  lif_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lif_datapath u_datapath (
    .clk             (clk),
    .regs            (regs),
    .cmd             (cmd),
    .status          (status),
    .in_neuron_id    (in_ch.neuron_id),
    .in_synaptic_sum (in_ch.synaptic_sum),
    .in_noise_sample (in_ch.noise_sample),
    .out_neuron_id   (out_ch.out_neuron_id),
    .out_fired       (out_ch.fired),
    .out_voltage     (out_ch.membrane_voltage)
  );

endmodule

// File: src/lif_checker.sv
// ----------------------------------------------------------------------------
// lif_checker
// Port-level checks on the neuron update block, bound to the top level.
// ----------------------------------------------------------------------------
module lif_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lif_pkg::ID_W-1:0]          out_neuron_id,
  input logic                              out_fired,
  input logic signed [lif_pkg::V_W-1:0]    out_voltage
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_neuron_id) &&
                                $stable(out_fired) && $stable(out_voltage))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in flight");

  // reset leaves both channels quiet while the state memory is swept
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channel active right after reset");

endmodule

bind lif_neuron_update lif_checker u_lif_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_neuron_id (out_ch.out_neuron_id),
  .out_fired     (out_ch.fired),
  .out_voltage   (out_ch.membrane_voltage)
);

// File: tb/tb_lif_neuron_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lif_neuron_update
// Self-checking bench for the LIF neuron update block. A behavioral model of
// the population state predicts every result. Directed corner beats are
// followed by random traffic on a small set of hot neurons under several
// parameter sets, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lif_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [ID_W-1:0]           id;
    logic signed [V_W-1:0]     syn;
    logic signed [NOISE_W-1:0] noise;
  } neuron_item_t;

  typedef struct {
    logic [ID_W-1:0]       id;
    logic                  fired;
    logic signed [V_W-1:0] voltage;
  } neuron_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lif_in_if  in_bus();
  lif_out_if out_bus();
  lif_cfg_if cfg_bus();

  lif_neuron_update dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #4 clk = ~clk;

  neuron_item_t   neuron_items[$];
  neuron_result_t pending_updates[$];
  neuron_item_t   bus_item;
  neuron_result_t want;
  bit             on_bus;
  int             src_idle_pct;
  int             sink_idle_pct;
  int             mismatch_count;

  cfg_t                  params;
  logic signed [V_W-1:0] membrane [NEURON_COUNT];
  logic [CNT_W-1:0]      refr_left [NEURON_COUNT];

  function automatic logic signed [V_W-1:0] clamp32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -80'sd2147483648) return 32'sh80000000;
    return x[V_W-1:0];
  endfunction

  function automatic logic signed [V_W-1:0] leak_and_drive(
    input logic signed [V_W-1:0]     v,
    input logic signed [V_W-1:0]     syn,
    input logic signed [NOISE_W-1:0] noise
  );
    logic signed [79:0]    a;
    logic signed [79:0]    b;
    logic signed [79:0]    c;
    logic signed [79:0]    leak;
    logic signed [V_W-1:0] drive;
    a = noise;
    b = $signed(params.noise_gain);
    c = syn;
    leak = $signed(params.bias_current);
    drive = clamp32(c + leak + ((a * b + 80'sd2048) >>> 12));
    a = params.decay_coeff;
    b = v;
    leak = a * b;
    a = params.input_gain;
    b = drive;
    return clamp32((leak + a * b + 80'sd8388608) >>> 24);
  endfunction

  function automatic neuron_result_t advance_neuron(input neuron_item_t it);
    neuron_result_t        r;
    logic signed [V_W-1:0] v;
    r.id = it.id;
    r.fired = 1'b0;
    r.voltage = '0;
    if (it.id < NEURON_COUNT) begin
      v = membrane[it.id];
      if (refr_left[it.id] != 0) begin
        refr_left[it.id] = refr_left[it.id] - 1'b1;
      end else if (v >= $signed(params.v_threshold)) begin
        r.fired = 1'b1;
        v = params.v_reset;
        refr_left[it.id] = params.refractory_steps;
      end else begin
        v = leak_and_drive(v, it.syn, it.noise);
      end
      membrane[it.id] = v;
      r.voltage = v;
    end
    return r;
  endfunction

  function automatic neuron_item_t random_item();
    neuron_item_t it;
    int           pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) it.id = ID_W'($urandom_range(0, 15));
    else if (pick == 8) it.id = ID_W'($urandom_range(1008, 1023));
    else it.id = ID_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) it.syn = $urandom;
    else if (pick == 1) it.syn = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    else it.syn = $signed(32'($urandom_range(0, 67108863))) - 32'sd33554432;
    if ($urandom_range(0, 19) == 0) it.noise = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    else it.noise = NOISE_W'($urandom);
    return it;
  endfunction

  function automatic cfg_t random_params();
    cfg_t p;
    p.decay_coeff      = DECAY_W'($urandom);
    p.input_gain       = $urandom_range(0, 32'h0200_0000);
    p.bias_current     = $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000;
    p.noise_gain       = $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000;
    p.v_threshold      = $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
    p.v_reset          = $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
    p.refractory_steps = CNT_W'($urandom_range(0, 8));
    return p;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      on_bus = 1'b0;
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pending_updates.push_back(advance_neuron(bus_item));
        on_bus = 1'b0;
      end
      if (!on_bus && neuron_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        bus_item = neuron_items.pop_front();
        in_bus.neuron_id    <= bus_item.id;
        in_bus.synaptic_sum <= bus_item.syn;
        in_bus.noise_sample <= bus_item.noise;
        on_bus = 1'b1;
      end
      in_bus.valid <= on_bus;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected beat id %0d fired %0b v %0d", $time,
                 out_bus.out_neuron_id, out_bus.fired, out_bus.membrane_voltage);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        if (out_bus.out_neuron_id !== want.id || out_bus.fired !== want.fired ||
            out_bus.membrane_voltage !== want.voltage) begin
          $display("%0t: expected id %0d fired %0b v %0d, got id %0d fired %0b v %0d",
                   $time, want.id, want.fired, want.voltage, out_bus.out_neuron_id,
                   out_bus.fired, out_bus.membrane_voltage);
          mismatch_count++;
        end
      end
    end
    out_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_DECAY_COEFF:      params.decay_coeff      = value[DECAY_W-1:0];
      REG_INPUT_GAIN:       params.input_gain       = value;
      REG_BIAS_CURRENT:     params.bias_current     = value;
      REG_NOISE_GAIN:       params.noise_gain       = value;
      REG_V_THRESHOLD:      params.v_threshold      = value;
      REG_V_RESET:          params.v_reset          = value;
      REG_REFRACTORY_STEPS: params.refractory_steps = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (neuron_items.size() != 0 || on_bus || pending_updates.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic switch_params(input cfg_t p);
    wait_drained();
    write_reg(REG_DECAY_COEFF, 32'(p.decay_coeff));
    write_reg(REG_INPUT_GAIN, p.input_gain);
    write_reg(REG_BIAS_CURRENT, p.bias_current);
    write_reg(REG_NOISE_GAIN, p.noise_gain);
    write_reg(REG_V_THRESHOLD, p.v_threshold);
    write_reg(REG_V_RESET, p.v_reset);
    write_reg(REG_REFRACTORY_STEPS, 32'(p.refractory_steps));
  endtask

  task automatic push_item(input logic [ID_W-1:0] id, input logic signed [V_W-1:0] syn,
                           input logic signed [NOISE_W-1:0] noise);
    neuron_item_t it;
    it.id = id;
    it.syn = syn;
    it.noise = noise;
    neuron_items.push_back(it);
  endtask

  task automatic random_phase(input cfg_t p, input int src_pct, input int sink_pct,
                              input int count);
    switch_params(p);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) neuron_items.push_back(random_item());
  endtask

  initial begin
    cfg_t typical;
    cfg_t sat_high;
    cfg_t sat_low;
    cfg_t fast_leak;
    typical   = '{decay_coeff: 24'd15099494, input_gain: 32'h0100_0000,
                  bias_current: 32'sh0199_999A, noise_gain: 32'sh00CC_CCCD,
                  v_threshold: 32'sh0100_0000, v_reset: 32'sh0, refractory_steps: 16'd3};
    sat_high  = '{decay_coeff: 24'hFF_FFFF, input_gain: 32'hFFFF_FFFF,
                  bias_current: 32'sh7FFF_FFFF, noise_gain: 32'sh7FFF_FFFF,
                  v_threshold: 32'sh7FFF_FFFF, v_reset: 32'sh8000_0000,
                  refractory_steps: 16'hFFFF};
    sat_low   = '{decay_coeff: 24'h0, input_gain: 32'h0, bias_current: 32'sh8000_0000,
                  noise_gain: 32'sh8000_0000, v_threshold: 32'sh8000_0000,
                  v_reset: 32'sh7FFF_FFFF, refractory_steps: 16'h0};
    fast_leak = '{decay_coeff: 24'h80_0000, input_gain: 32'h0200_0000,
                  bias_current: 32'shFFF3_3334, noise_gain: 32'shFFE6_6666,
                  v_threshold: 32'sh0080_0000, v_reset: 32'shFF80_0000,
                  refractory_steps: 16'h0};

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.neuron_id = '0;
    in_bus.synaptic_sum = '0;
    in_bus.noise_sample = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    on_bus = 1'b0;
    mismatch_count = 0;
    params = '0;
    for (int i = 0; i < NEURON_COUNT; i++) begin
      membrane[i] = '0;
      refr_left[i] = '0;
    end
    src_idle_pct = 29;
    sink_idle_pct = 65;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // unused register index, then the reset parameter set
    write_reg(REG_NONE, $urandom);
    push_item(10'd3, 32'sh0100_0000, 16'sh1000);
    push_item(10'd3, 32'sh8000_0000, 16'sh8000);

    switch_params(typical);
    push_item(10'd0, 32'sh7FFF_FFFF, 16'sh7FFF);
    push_item(10'd0, 32'sh8000_0000, 16'sh8000);
    push_item(10'd1023, 32'sh8000_0000, 16'sh8000);
    push_item(10'd1023, 32'sh0, 16'sh0);
    push_item(10'h2AA, 32'sh5555_5555, 16'sh5555);
    push_item(10'h155, 32'shAAAA_AAAA, 16'shAAAA);
    repeat (6) push_item(10'd5, 32'sh0080_0000, 16'sh0800);

    // zero refractory with reset above threshold: fires every step
    switch_params(sat_low);
    repeat (3) push_item(10'd6, 32'sh0100_0000, 16'sh7FFF);
    repeat (2) push_item(10'd1023, 32'sh7FFF_FFFF, 16'sh8000);

    switch_params(sat_high);
    repeat (6) push_item(10'd9, 32'sh7FFF_FFFF, 16'sh7FFF);

    // sender holds off until all results are back before each parameter switch
    random_phase(typical, 29, 65, 100);
    random_phase(typical, 29, 65, 100);
    random_phase(fast_leak, 29, 65, 180);
    random_phase(random_params(), 65, 29, 180);
    random_phase(sat_high, 65, 29, 180);
    random_phase(random_params(), 0, 0, 180);
    random_phase(sat_low, 0, 0, 180);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
